// ----- hw/rtl/console_command_tokenizer_match_assert.svh -----
// ----------------------------------------------------------------------------
// Console command tokenizer: assertion macros
// Shorthand for clocked properties checked at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_COMMAND_TOKENIZER_MATCH_ASSERT_SVH
`define CONSOLE_COMMAND_TOKENIZER_MATCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCTM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCTM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cctm_pkg.sv -----
// ----------------------------------------------------------------------------
// Console command tokenizer: package
// Character codes, sizes, register map and the case fold helper.
// ----------------------------------------------------------------------------
package cctm_pkg;

  localparam int KEY_MAX_CHARS = 8;
  localparam int MAX_ARGS      = 16;

  localparam int CNT_W    = 5;                       // token count / arg_count
  localparam int POS_W    = 4;                       // first token position
  localparam int KEY_W    = 8 * KEY_MAX_CHARS;
  localparam int KIDX_W   = $clog2(KEY_MAX_CHARS);
  localparam int KLEN_W   = 4;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 5;

  localparam logic [POS_W-1:0] FIRST_DONE = 4'd15;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // register index = paddr[4:3]
  localparam logic [1:0] REG_KEYWORD  = 2'd0;
  localparam logic [1:0] REG_KEY_LEN  = 2'd1;
  localparam logic [1:0] REG_CASE     = 2'd2;
  localparam logic [1:0] REG_MIN_PAR  = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] arg_count;
    logic             name_match;
    logic             first_match_res;
    logic             found;
    logic             end_of_text;
  } result_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h20;
    return r;
  endfunction

endpackage

// ----- hw/rtl/console_command_tokenizer_match.sv -----
// ----------------------------------------------------------------------------
// Console command tokenizer with keyword match
// Splits a console byte stream into commands and tokens and matches the
// first token of each command against a programmable keyword.
// ----------------------------------------------------------------------------
// Feed one text byte per word on the char channel. Spaces separate tokens,
// ';' closes a command and byte 0 closes the command and the whole text.
// Every ';' or 0 byte yields one result word: the token count (saturated at
// 16), whether the first token equals the keyword (exact or ASCII upper-case
// folded, per case_sensitive), whether this is the first match in the text,
// and found = first match with at least min_params tokens. Other bytes give
// no result. The block takes one byte per clock: each byte goes through a
// single classify/compare/count step straight into the state and result
// registers, so throughput is set by that one register stage. A byte is
// held off only while a result word sits in the output register and the
// sink stalls it. Program the registers over APB (64-bit data, register i
// at byte address 8*i) only while the stream is idle.
// ----------------------------------------------------------------------------
`include "console_command_tokenizer_match_assert.svh"

module console_command_tokenizer_match (
  input  logic                         clk,
  input  logic                         rst,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cctm_pkg::ADDR_W-1:0]  paddr,
  input  logic [cctm_pkg::DATA_W-1:0]  pwdata,
  output logic [cctm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // text byte channel
  input  logic                         char_valid,
  output logic                         char_stall,
  input  logic [7:0]                   char_byte,
  // result channel
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [cctm_pkg::CNT_W-1:0]   arg_count,
  output logic                         name_match,
  output logic                         first_match_res,
  output logic                         found,
  output logic                         end_of_text
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [cctm_pkg::KEY_W-1:0]  keyword;
  logic [cctm_pkg::KLEN_W-1:0] keyword_len;
  logic                        case_sensitive;
  logic [cctm_pkg::CNT_W-1:0]  min_params;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keyword        <= '0;
      keyword_len    <= cctm_pkg::KLEN_W'(1);
      case_sensitive <= 1'b0;
      min_params     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cctm_pkg::REG_KEYWORD: keyword        <= pwdata[cctm_pkg::KEY_W-1:0];
        cctm_pkg::REG_KEY_LEN: keyword_len    <= pwdata[cctm_pkg::KLEN_W-1:0];
        cctm_pkg::REG_CASE:    case_sensitive <= pwdata[0];
        cctm_pkg::REG_MIN_PAR: min_params     <= pwdata[cctm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      cctm_pkg::REG_KEYWORD: prdata[cctm_pkg::KEY_W-1:0]  = keyword;
      cctm_pkg::REG_KEY_LEN: prdata[cctm_pkg::KLEN_W-1:0] = keyword_len;
      cctm_pkg::REG_CASE:    prdata[0]                    = case_sensitive;
      cctm_pkg::REG_MIN_PAR: prdata[cctm_pkg::CNT_W-1:0]  = min_params;
      default: ;
    endcase
  end

  // Effective keyword length, saturated at the key buffer size.
  logic [cctm_pkg::KLEN_W-1:0] klen;
  assign klen = (keyword_len > cctm_pkg::KLEN_W'(cctm_pkg::KEY_MAX_CHARS)) ?
                cctm_pkg::KLEN_W'(cctm_pkg::KEY_MAX_CHARS) : keyword_len;

  // --------------------------------------------------------------------------
  // Tokenizer state
  // --------------------------------------------------------------------------
  logic                       in_token,       in_token_next;
  logic [cctm_pkg::CNT_W-1:0] token_count,    token_count_next;
  logic [cctm_pkg::POS_W-1:0] first_pos,      first_pos_next;
  logic                       first_equal,    first_equal_next;
  logic                       matched_before, matched_before_next;

  logic char_acc;
  logic is_nul, is_term, is_space;
  assign char_acc = char_valid && !char_stall;
  assign is_nul   = (char_byte == cctm_pkg::CH_NUL);
  assign is_term  = is_nul || (char_byte == cctm_pkg::CH_SEMI);
  assign is_space = (char_byte == cctm_pkg::CH_SPACE);

  // keyword byte at the current first-token position
  logic [7:0] key_byte;
  logic       same_char;
  assign key_byte  = keyword[first_pos[cctm_pkg::KIDX_W-1:0]*8 +: 8];
  assign same_char = case_sensitive ? (key_byte == char_byte) :
                     (cctm_pkg::fold_upper(key_byte) == cctm_pkg::fold_upper(char_byte));

  // command-end evaluation; first token may still be open here
  logic             eq_end;
  cctm_pkg::result_t res_now;
  always_comb begin
    eq_end = (first_pos == cctm_pkg::FIRST_DONE) ? first_equal :
             (first_equal && (first_pos == cctm_pkg::POS_W'(klen)));
    res_now.arg_count       = token_count;
    res_now.name_match      = (token_count != '0) && (klen != '0) && eq_end;
    res_now.first_match_res = res_now.name_match && !matched_before;
    res_now.found           = res_now.first_match_res && (token_count >= min_params);
    res_now.end_of_text     = is_nul;
  end

  always_comb begin
    in_token_next       = in_token;
    token_count_next    = token_count;
    first_pos_next      = first_pos;
    first_equal_next    = first_equal;
    matched_before_next = matched_before;
    if (char_acc) begin
      if (is_term) begin
        // close command; byte 0 also forgets earlier matches
        in_token_next       = 1'b0;
        token_count_next    = '0;
        first_pos_next      = '0;
        first_equal_next    = 1'b1;
        matched_before_next = is_nul ? 1'b0 : (matched_before || res_now.name_match);
      end else if (is_space) begin
        if (in_token && first_pos != cctm_pkg::FIRST_DONE) begin
          first_equal_next = first_equal && (first_pos == cctm_pkg::POS_W'(klen));
          first_pos_next   = cctm_pkg::FIRST_DONE;
        end
        in_token_next = 1'b0;
      end else begin
        if (!in_token) begin
          in_token_next = 1'b1;
          if (token_count < cctm_pkg::CNT_W'(cctm_pkg::MAX_ARGS))
            token_count_next = token_count + 1'b1;
        end
        if (first_pos != cctm_pkg::FIRST_DONE) begin
          // past the keyword end any character is a mismatch
          if (first_pos < cctm_pkg::POS_W'(klen)) begin
            if (!same_char) first_equal_next = 1'b0;
          end else begin
            first_equal_next = 1'b0;
          end
          if (first_pos <= cctm_pkg::POS_W'(cctm_pkg::KEY_MAX_CHARS))
            first_pos_next = first_pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token       <= 1'b0;
      token_count    <= '0;
      first_pos      <= '0;
      first_equal    <= 1'b1;
      matched_before <= 1'b0;
    end else begin
      in_token       <= in_token_next;
      token_count    <= token_count_next;
      first_pos      <= first_pos_next;
      first_equal    <= first_equal_next;
      matched_before <= matched_before_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic res_load;
  assign res_load   = char_acc && is_term;
  // hold input only while a result word is parked and stalled
  assign char_stall = res_valid && res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      arg_count       <= res_now.arg_count;
      name_match      <= res_now.name_match;
      first_match_res <= res_now.first_match_res;
      found           <= res_now.found;
      end_of_text     <= res_now.end_of_text;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CCTM_ASSERT_NOW(a_flag_chain, res_valid,
    (!found || first_match_res) && (!first_match_res || name_match),
    "found/first_match_res without the weaker flag")
  `CCTM_ASSERT_NOW(a_empty_no_match, res_valid && arg_count == '0, !name_match,
    "name match on an empty command")
  `CCTM_ASSERT_NEXT(a_term_gives_result, char_acc && is_term, res_valid,
    "command end did not load a result word")
  `CCTM_ASSERT_NEXT(a_eot_clears, char_acc && is_nul,
    token_count == '0 && first_pos == '0 && !matched_before && !in_token,
    "state not cleared after end of text")

endmodule
